// ----- design/rsi_pkg.sv -----
// rsi_pkg: shared types and constants of the relative strength index block
// holds the sequencer state type, the sequencer control and status structs
// no dependencies
package rsi_pkg;

	localparam int PRICE_W        = 32;
	localparam int PERIOD_W       = 9;
	localparam int RSI_W          = 23;
	localparam int RSI_FRAC       = 16;
	localparam int SPAN_BITS      = 40;
	localparam int PCT_W          = 7;
	localparam int MAX_PERIOD_DEF = 256;
	localparam int AVG_FRAC_DEF   = 16;
	localparam int QUOT_W_DEF     = 64;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd14;
	localparam logic [PCT_W-1:0]    RSI_PCT      = 7'd100;
	localparam logic [RSI_W-1:0]    RSI_HUNDRED  = 23'd6553600;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_LD_GAIN,
		ST_WT_GAIN,
		ST_LD_LOSS,
		ST_WT_LOSS,
		ST_NORM,
		ST_LD_RATIO,
		ST_WT_RATIO,
		ST_DONE
	} rsi_state_t;

	typedef struct packed {
		logic item_in;
		logic restart;
		logic warm_more;
		logic div_done;
		logic norm_stop;
		logic short_cut;
		logic out_free;
	} seq_status_t;

	typedef struct packed {
		logic accept;
		logic delta;
		logic launch_g;
		logic wait_g;
		logic launch_l;
		logic wait_l;
		logic norm;
		logic launch_r;
		logic wait_r;
		logic finish;
	} seq_ctrl_t;

endpackage

// ----- design/rsi_div.sv -----
// rsi_div: shared restoring divider, one quotient bit per cycle
// dividend arrives left-justified with its bit count; quotient lands in the low bits
// depends on rsi_pkg
module rsi_div #(
	parameter int QUOT_W = rsi_pkg::QUOT_W_DEF,
	parameter int DIV_W  = rsi_pkg::SPAN_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [$clog2(QUOT_W+1)-1:0] bits,
	input  logic [QUOT_W-1:0]           dividend,
	input  logic [DIV_W-1:0]            divisor,
	output logic                        done,
	output logic [QUOT_W-1:0]           quotient,
	output logic                        rem_nz
);
	import rsi_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [QUOT_W-1:0] acc_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   trial_diff;
	logic             take;

	assign trial      = {rem_q, acc_q[QUOT_W-1]};
	assign take       = trial >= {1'b0, dsr_q};
	assign trial_diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= bits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[QUOT_W-2:0], take};
			rem_q <= take ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;
	assign rem_nz   = rem_q != '0;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start && (cnt_q == CNT_W'(1)) |=> done_q && !busy_q)
		else $error("divider missed its last step");
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start))
		else $error("divider busy without a start");
`endif

endmodule

// ----- design/rsi_seq.sv -----
// rsi_seq: sequencer that steps one price item through the shared divider
// consumes status from the datapath and issues one-hot step controls
// depends on rsi_pkg
module rsi_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsi_pkg::seq_status_t status,
	output rsi_pkg::seq_ctrl_t   ctrl
);
	import rsi_pkg::*;

	rsi_state_t state_q;
	rsi_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.item_in) state_d = ST_DELTA;
			end
			ST_DELTA: begin
				if (status.restart || status.warm_more) state_d = ST_DONE;
				else state_d = ST_LD_GAIN;
			end
			ST_LD_GAIN: state_d = ST_WT_GAIN;
			ST_WT_GAIN: begin
				if (status.div_done) state_d = ST_LD_LOSS;
			end
			ST_LD_LOSS: state_d = ST_WT_LOSS;
			ST_WT_LOSS: begin
				if (status.div_done) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (status.norm_stop) begin
					state_d = status.short_cut ? ST_DONE : ST_LD_RATIO;
				end
			end
			ST_LD_RATIO: state_d = ST_WT_RATIO;
			ST_WT_RATIO: begin
				if (status.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE:     ctrl.accept   = 1'b1;
			ST_DELTA:    ctrl.delta    = 1'b1;
			ST_LD_GAIN:  ctrl.launch_g = 1'b1;
			ST_WT_GAIN:  ctrl.wait_g   = 1'b1;
			ST_LD_LOSS:  ctrl.launch_l = 1'b1;
			ST_WT_LOSS:  ctrl.wait_l   = 1'b1;
			ST_NORM:     ctrl.norm     = 1'b1;
			ST_LD_RATIO: ctrl.launch_r = 1'b1;
			ST_WT_RATIO: ctrl.wait_r   = 1'b1;
			ST_DONE:     ctrl.finish   = 1'b1;
			default:     ctrl          = '0;
		endcase
	end

endmodule

// ----- design/relative_strength_index.sv -----
// relative_strength_index: wilder rsi over a stream of q16.16 closing prices
// top level with the datapath; uses rsi_seq for sequencing and rsi_div for division
// depends on rsi_pkg, rsi_div, rsi_seq
//
//   channel | signals                                 | handshake
//   --------+-----------------------------------------+---------------------------
//   price   | close_price, series_start               | price_valid / price_stall
//   result  | rsi_value, rsi_valid                    | result_valid / result_stall
//   config  | cfg_wdata (rsi_period)                  | cfg_we, no wait
//
// a series start or warm-up item steps through accept, update and hand-off only
// an item that closes warm-up divides both sums by the period, then runs the shift
// search and the ratio division; a smoothing item runs the two smoothing divisions,
// the shift search and the ratio division; the serial divider, one quotient bit per
// cycle, does each division, and the shift search narrows the sum of the averages
// to the divisor width first; a zero average loss skips the ratio division
// reset sets the period to 14 and clears the price history; no clearing pass
// result_stall holds the output register; the next price is taken while a result
// waits, and that item then parks in its final step until the output frees up
module relative_strength_index #(
	parameter int MAX_PERIOD    = rsi_pkg::MAX_PERIOD_DEF,
	parameter int AVG_FRAC_BITS = rsi_pkg::AVG_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rsi_pkg::PERIOD_W-1:0]  cfg_wdata,
	input  logic                          price_valid,
	output logic                          price_stall,
	input  logic [rsi_pkg::PRICE_W-1:0]   close_price,
	input  logic                          series_start,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [rsi_pkg::RSI_W-1:0]     rsi_value,
	output logic                          rsi_valid
);
	import rsi_pkg::*;

	// average width: q16.(16+frac) after warm-up, raw q16.16 sums during it
	localparam int AVG_W      = PRICE_W + AVG_FRAC_BITS;
	localparam int N_W        = $clog2(MAX_PERIOD + 1);
	localparam int FIRST_BITS = AVG_W + AVG_FRAC_BITS;
	localparam int PROD_W     = SPAN_BITS + PCT_W;
	localparam int RATIO_BITS = PROD_W + RSI_FRAC;
	localparam int QUOT_W     = (FIRST_BITS > RATIO_BITS) ? FIRST_BITS : RATIO_BITS;
	localparam int CNT_W      = $clog2(QUOT_W + 1);

	seq_status_t status;
	seq_ctrl_t   ctrl;

	// configuration and series history
	logic [PERIOD_W-1:0] period_q;
	logic [PRICE_W-1:0]  prev_q;
	logic                have_q;
	logic [N_W-1:0]      cnt_q;
	logic [AVG_W-1:0]    avg_g_q;
	logic [AVG_W-1:0]    avg_l_q;

	// per-item working registers
	logic [PRICE_W-1:0]  price_q;
	logic                start_q;
	logic [PRICE_W-1:0]  gain_q;
	logic [PRICE_W-1:0]  loss_q;
	logic                smooth_q;
	logic                neg_q;
	logic [AVG_W-1:0]    gs_q;
	logic [AVG_W-1:0]    ls_q;
	logic                lz_q;
	logic [RSI_W-1:0]    res_value_q;
	logic                res_valid_q;

	// output register
	logic                out_valid_q;
	logic [RSI_W-1:0]    rsi_value_q;
	logic                rsi_valid_q;

	logic [N_W-1:0]      n;
	logic                restart;
	logic                up;
	logic [PRICE_W-1:0]  gain;
	logic [PRICE_W-1:0]  loss;
	logic                warm;
	logic [N_W-1:0]      cnt_inc;

	logic [AVG_W-1:0]    cur_avg;
	logic [PRICE_W-1:0]  cur_chg;
	logic [AVG_W-1:0]    x_val;
	logic                x_neg;
	logic [AVG_W-1:0]    mag;
	logic [AVG_W-1:0]    avg_op;
	logic [AVG_W-1:0]    q_avg;
	logic [AVG_W-1:0]    fixed_avg;
	logic [AVG_W:0]      t_sum;
	logic [PROD_W-1:0]   prod;

	logic                div_start;
	logic [CNT_W-1:0]    div_bits;
	logic [QUOT_W-1:0]   div_dividend;
	logic [SPAN_BITS-1:0] div_divisor;
	logic                div_done;
	logic [QUOT_W-1:0]   div_quot;
	logic                div_rem_nz;

	// period clamped to 1..MAX_PERIOD; zero acts as one
	always_comb begin
		if (period_q == '0) begin
			n = N_W'(1);
		end else if (int'(period_q) > MAX_PERIOD) begin
			n = N_W'(MAX_PERIOD);
		end else begin
			n = N_W'(period_q);
		end
	end

	// price change split into gain and loss; no change counts as a zero loss
	assign restart = start_q || !have_q;
	assign up      = price_q > prev_q;
	assign gain    = up ? (price_q - prev_q) : '0;
	assign loss    = up ? '0 : (prev_q - price_q);
	assign warm    = cnt_q < n;
	assign cnt_inc = cnt_q + N_W'(1);

	// divider operand: raw sum for the first average, |x - avg| for smoothing
	assign cur_avg = (ctrl.launch_l || ctrl.wait_l) ? avg_l_q : avg_g_q;
	assign cur_chg = ctrl.launch_l ? loss_q : gain_q;
	assign x_val   = {cur_chg, {AVG_FRAC_BITS{1'b0}}};
	assign x_neg   = x_val < cur_avg;
	assign mag     = x_neg ? (cur_avg - x_val) : (x_val - cur_avg);
	assign avg_op  = smooth_q ? mag : cur_avg;

	// a step below the average rounds toward minus infinity: subtract the ceiling
	assign q_avg = div_quot[AVG_W-1:0];
	always_comb begin
		if (!smooth_q) begin
			fixed_avg = q_avg;
		end else if (neg_q) begin
			fixed_avg = cur_avg - q_avg - AVG_W'(div_rem_nz);
		end else begin
			fixed_avg = cur_avg + q_avg;
		end
	end

	// shift search and ratio operands
	assign t_sum = {1'b0, gs_q} + {1'b0, ls_q};
	assign prod  = {{PCT_W{1'b0}}, gs_q[SPAN_BITS-1:0]} * PROD_W'(RSI_PCT);

	assign div_start = ctrl.launch_g || ctrl.launch_l || ctrl.launch_r;
	always_comb begin
		if (ctrl.launch_r) begin
			div_bits     = CNT_W'(RATIO_BITS);
			div_dividend = {prod, {(QUOT_W-PROD_W){1'b0}}};
			div_divisor  = t_sum[SPAN_BITS-1:0];
		end else begin
			div_bits     = smooth_q ? CNT_W'(AVG_W) : CNT_W'(FIRST_BITS);
			div_dividend = {avg_op, {(QUOT_W-AVG_W){1'b0}}};
			div_divisor  = {{(SPAN_BITS-N_W){1'b0}}, n};
		end
	end

	rsi_div #(
		.QUOT_W (QUOT_W),
		.DIV_W  (SPAN_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.bits     (div_bits),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot),
		.rem_nz   (div_rem_nz)
	);

	// sequencer status
	assign status.item_in   = price_valid && !price_stall;
	assign status.restart   = restart;
	assign status.warm_more = warm && (cnt_inc < n);
	assign status.div_done  = div_done;
	assign status.norm_stop = lz_q || (t_sum[AVG_W:SPAN_BITS] == '0);
	assign status.short_cut = lz_q || (t_sum == '0);
	assign status.out_free  = !out_valid_q || !result_stall;

	rsi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// configuration and series history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			prev_q   <= '0;
			have_q   <= 1'b0;
			cnt_q    <= '0;
			avg_g_q  <= '0;
			avg_l_q  <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (ctrl.delta) begin
				prev_q <= price_q;
				have_q <= 1'b1;
				if (restart) begin
					cnt_q   <= '0;
					avg_g_q <= '0;
					avg_l_q <= '0;
				end else if (warm) begin
					// warm-up: plain sums, wrapping at the average width
					cnt_q   <= cnt_inc;
					avg_g_q <= avg_g_q + {{AVG_FRAC_BITS{1'b0}}, gain};
					avg_l_q <= avg_l_q + {{AVG_FRAC_BITS{1'b0}}, loss};
				end
			end
			if (ctrl.wait_g && div_done) begin
				avg_g_q <= fixed_avg;
			end
			if (ctrl.wait_l && div_done) begin
				avg_l_q <= fixed_avg;
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (status.item_in) begin
			price_q <= close_price;
			start_q <= series_start;
		end
		if (ctrl.delta) begin
			gain_q      <= gain;
			loss_q      <= loss;
			smooth_q    <= !warm;
			res_value_q <= '0;
			res_valid_q <= 1'b0;
		end
		if (ctrl.launch_g || ctrl.launch_l) begin
			neg_q <= x_neg;
		end
		// the shift search starts from the fresh averages
		if (ctrl.wait_l && div_done) begin
			gs_q <= avg_g_q;
			ls_q <= fixed_avg;
			lz_q <= fixed_avg == '0;
		end
		if (ctrl.norm) begin
			if (!status.norm_stop) begin
				gs_q <= gs_q >> 1;
				ls_q <= ls_q >> 1;
			end else if (status.short_cut) begin
				// zero average loss reads as a full hundred
				res_value_q <= RSI_HUNDRED;
				res_valid_q <= 1'b1;
			end
		end
		if (ctrl.wait_r && div_done) begin
			res_value_q <= div_quot[RSI_W-1:0];
			res_valid_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish && status.out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish && status.out_free) begin
			rsi_value_q <= res_value_q;
			rsi_valid_q <= res_valid_q;
		end
	end

	assign price_stall  = !ctrl.accept;
	assign result_valid = out_valid_q;
	assign rsi_value    = rsi_value_q;
	assign rsi_valid    = rsi_valid_q;

`ifndef SYNTHESIS
	a_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !rsi_valid |-> rsi_value == '0)
		else $error("warm-up item carries a nonzero value");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && rsi_valid |-> rsi_value <= RSI_HUNDRED)
		else $error("rsi above one hundred");
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		price_valid && !price_stall |=> price_stall)
		else $error("price taken twice in a row");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= N_W'(MAX_PERIOD))
		else $error("change count past the longest period");
`endif

endmodule
